FILE: hw/rtl/lmts_pkg.sv
// ----------------------------------------------------------------------------
// lmts_pkg: shared types, constants and font for the LED matrix text scroller
// Holds the 5x7 ASCII font, command codes and the front/back queue entry type.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int MODULES     = 4;
  localparam int TEXT_DEPTH  = 256;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int RING_BITS   = MODULES * 8;
  localparam int MOD_W       = 2;
  localparam logic [7:0] GAP_RESET = 8'd24;
  localparam logic [2:0] GLYPH_WIDTH = 3'd5;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam logic [0:0] CFG_TEXT_LENGTH = 1'd0;
  localparam logic [0:0] CFG_GAP_COLUMNS = 1'd1;

  // operation handed from front to back
  typedef struct packed {
    logic       clear;     // 1 clear frame, 0 shift in column
    logic       right;
    logic [7:0] column;
    logic [7:0] laps;
  } op_t;

  function automatic logic [7:0] glyph_bits(input logic [7:0] code, input logic [2:0] col);
    logic [34:0] g;
    logic [7:0]  c;
    begin
      c = code - 8'd32;
      case (c)
        8'd0:  g = {7'd0,7'd0,7'd0,7'd0,7'd0};
        8'd1:  g = {7'd0,7'd0,7'd125,7'd0,7'd0};
        8'd2:  g = {7'd0,7'd112,7'd0,7'd112,7'd0};
        8'd3:  g = {7'd20,7'd62,7'd20,7'd62,7'd20};
        8'd4:  g = {7'd36,7'd42,7'd127,7'd42,7'd18};
        8'd5:  g = {7'd35,7'd19,7'd8,7'd100,7'd98};
        8'd6:  g = {7'd9,7'd38,7'd89,7'd89,7'd38};
        8'd7:  g = {7'd0,7'd0,7'd96,7'd0,7'd0};
        8'd8:  g = {7'd0,7'd0,7'd0,7'd65,7'd62};
        8'd9:  g = {7'd62,7'd65,7'd0,7'd0,7'd0};
        8'd10: g = {7'd0,7'd16,7'd56,7'd16,7'd0};
        8'd11: g = {7'd8,7'd8,7'd62,7'd8,7'd8};
        8'd12: g = {7'd0,7'd0,7'd6,7'd1,7'd0};
        8'd13: g = {7'd8,7'd8,7'd8,7'd8,7'd8};
        8'd14: g = {7'd0,7'd0,7'd1,7'd0,7'd0};
        8'd15: g = {7'd32,7'd16,7'd8,7'd4,7'd2};
        8'd16: g = {7'd62,7'd65,7'd65,7'd65,7'd62};
        8'd17: g = {7'd1,7'd1,7'd127,7'd33,7'd17};
        8'd18: g = {7'd49,7'd73,7'd69,7'd67,7'd33};
        8'd19: g = {7'd54,7'd73,7'd65,7'd65,7'd34};
        8'd20: g = {7'd127,7'd8,7'd8,7'd8,7'd120};
        8'd21: g = {7'd70,7'd73,7'd73,7'd73,7'd122};
        8'd22: g = {7'd38,7'd73,7'd73,7'd73,7'd62};
        8'd23: g = {7'd96,7'd80,7'd79,7'd64,7'd64};
        8'd24: g = {7'd54,7'd73,7'd73,7'd73,7'd54};
        8'd25: g = {7'd62,7'd73,7'd73,7'd73,7'd50};
        8'd26: g = {7'd0,7'd0,7'd20,7'd0,7'd0};
        8'd27: g = {7'd0,7'd0,7'd22,7'd1,7'd0};
        8'd28: g = {7'd65,7'd34,7'd20,7'd8,7'd0};
        8'd29: g = {7'd20,7'd20,7'd20,7'd20,7'd20};
        8'd30: g = {7'd0,7'd8,7'd20,7'd34,7'd65};
        8'd31: g = {7'd48,7'd72,7'd77,7'd32,7'd0};
        8'd32: g = {7'd61,7'd85,7'd93,7'd65,7'd62};
        8'd33: g = {7'd63,7'd72,7'd72,7'd72,7'd63};
        8'd34: g = {7'd54,7'd73,7'd73,7'd73,7'd127};
        8'd35: g = {7'd54,7'd65,7'd65,7'd65,7'd62};
        8'd36: g = {7'd62,7'd65,7'd65,7'd65,7'd127};
        8'd37: g = {7'd65,7'd73,7'd73,7'd73,7'd127};
        8'd38: g = {7'd64,7'd72,7'd72,7'd72,7'd127};
        8'd39: g = {7'd54,7'd69,7'd69,7'd65,7'd62};
        8'd40: g = {7'd127,7'd8,7'd8,7'd8,7'd127};
        8'd41: g = {7'd65,7'd65,7'd127,7'd65,7'd65};
        8'd42: g = {7'd126,7'd65,7'd65,7'd65,7'd70};
        8'd43: g = {7'd65,7'd34,7'd20,7'd8,7'd127};
        8'd44: g = {7'd1,7'd1,7'd1,7'd1,7'd127};
        8'd45: g = {7'd127,7'd32,7'd16,7'd32,7'd127};
        8'd46: g = {7'd127,7'd4,7'd8,7'd16,7'd127};
        8'd47: g = {7'd62,7'd65,7'd65,7'd65,7'd62};
        8'd48: g = {7'd48,7'd72,7'd72,7'd72,7'd127};
        8'd49: g = {7'd61,7'd66,7'd70,7'd66,7'd60};
        8'd50: g = {7'd49,7'd74,7'd76,7'd72,7'd127};
        8'd51: g = {7'd50,7'd69,7'd73,7'd81,7'd38};
        8'd52: g = {7'd64,7'd64,7'd127,7'd64,7'd64};
        8'd53: g = {7'd126,7'd1,7'd1,7'd1,7'd126};
        8'd54: g = {7'd124,7'd2,7'd1,7'd2,7'd124};
        8'd55: g = {7'd127,7'd2,7'd4,7'd2,7'd127};
        8'd56: g = {7'd99,7'd20,7'd8,7'd20,7'd99};
        8'd57: g = {7'd96,7'd16,7'd15,7'd16,7'd96};
        8'd58: g = {7'd97,7'd81,7'd73,7'd69,7'd67};
        8'd59: g = {7'd0,7'd65,7'd65,7'd127,7'd0};
        8'd60: g = {7'd1,7'd6,7'd8,7'd48,7'd64};
        8'd61: g = {7'd0,7'd127,7'd65,7'd65,7'd0};
        8'd62: g = {7'd8,7'd16,7'd32,7'd16,7'd8};
        8'd63: g = {7'd1,7'd1,7'd1,7'd1,7'd1};
        8'd64: g = {7'd0,7'd0,7'd0,7'd96,7'd16};
        8'd65: g = {7'd1,7'd14,7'd17,7'd17,7'd14};
        8'd66: g = {7'd0,7'd6,7'd9,7'd9,7'd63};
        8'd67: g = {7'd0,7'd10,7'd17,7'd17,7'd14};
        8'd68: g = {7'd0,7'd63,7'd9,7'd9,7'd6};
        8'd69: g = {7'd0,7'd13,7'd21,7'd21,7'd14};
        8'd70: g = {7'd0,7'd36,7'd36,7'd31,7'd0};
        8'd71: g = {7'd0,7'd30,7'd37,7'd37,7'd25};
        8'd72: g = {7'd0,7'd7,7'd8,7'd8,7'd63};
        8'd73: g = {7'd0,7'd0,7'd47,7'd0,7'd0};
        8'd74: g = {7'd0,7'd94,7'd1,7'd1,7'd2};
        8'd75: g = {7'd0,7'd17,7'd10,7'd4,7'd63};
        8'd76: g = {7'd0,7'd0,7'd63,7'd0,7'd0};
        8'd77: g = {7'd15,7'd16,7'd8,7'd16,7'd15};
        8'd78: g = {7'd0,7'd15,7'd16,7'd8,7'd31};
        8'd79: g = {7'd0,7'd14,7'd17,7'd17,7'd14};
        8'd80: g = {7'd0,7'd24,7'd36,7'd36,7'd63};
        8'd81: g = {7'd0,7'd63,7'd36,7'd36,7'd24};
        8'd82: g = {7'd0,7'd16,7'd16,7'd8,7'd31};
        8'd83: g = {7'd0,7'd18,7'd37,7'd41,7'd18};
        8'd84: g = {7'd0,7'd9,7'd9,7'd62,7'd0};
        8'd85: g = {7'd0,7'd30,7'd1,7'd1,7'd30};
        8'd86: g = {7'd28,7'd2,7'd1,7'd2,7'd28};
        8'd87: g = {7'd30,7'd1,7'd2,7'd1,7'd30};
        8'd88: g = {7'd17,7'd10,7'd4,7'd10,7'd17};
        8'd89: g = {7'd32,7'd16,7'd15,7'd16,7'd32};
        8'd90: g = {7'd17,7'd25,7'd21,7'd19,7'd17};
        8'd91: g = {7'd0,7'd65,7'd65,7'd54,7'd8};
        8'd92: g = {7'd0,7'd0,7'd127,7'd0,7'd0};
        8'd93: g = {7'd8,7'd54,7'd65,7'd65,7'd0};
        8'd94: g = {7'd0,7'd24,7'd8,7'd12,7'd0};
        default: g = '0;
      endcase
      // column 0 sits in the low seven bits
      case (col)
        3'd0: glyph_bits = {1'b0, g[6:0]};
        3'd1: glyph_bits = {1'b0, g[13:7]};
        3'd2: glyph_bits = {1'b0, g[20:14]};
        3'd3: glyph_bits = {1'b0, g[27:21]};
        3'd4: glyph_bits = {1'b0, g[34:28]};
        default: glyph_bits = 8'd0;
      endcase
    end
  endfunction

endpackage

FILE: hw/rtl/led_matrix_text_scroller.sv
// ----------------------------------------------------------------------------
// led_matrix_text_scroller: scrolling 5x7 text on four chained 8x8 modules
// A tick (kind 0) shifts the frame one column and emits four module images;
// a clear (kind 2) blanks the frame and emits four images; a text write
// (kind 1) emits nothing. Each tick or clear sends one image per module over
// the single image output port, which sets the sustained rate; an output
// stall holds the current image. The sequencer stalls its input after each
// tick for the text store read; a two-entry queue lets it run ahead while
// images are still being taken. The frame has reset, no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_text_index,
  input  logic [7:0]  in_char_code,
  input  logic        in_direction,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_module_index,
  output logic [63:0] out_module_rows,
  output logic [7:0]  out_lap_count,
  output logic        out_last
);

  logic [7:0]    text_length_r, gap_columns_r;
  logic          fq_valid, q_full, q_valid, q_pop;
  lmts_pkg::op_t fq_op, q_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= '0;
      gap_columns_r <= lmts_pkg::GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lmts_pkg::CFG_TEXT_LENGTH: text_length_r <= cfg_data;
        lmts_pkg::CFG_GAP_COLUMNS: gap_columns_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lmts_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_text_index, .in_char_code,
    .in_direction, .in_restart,
    .text_length (text_length_r),
    .gap_columns (gap_columns_r),
    .op_valid    (fq_valid),
    .op          (fq_op),
    .op_full     (q_full)
  );

  lmts_queue u_queue (
    .clk, .rst_n,
    .push      (fq_valid),
    .wdata     (fq_op),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .rdata     (q_op)
  );

  lmts_back u_back (
    .clk, .rst_n,
    .op_valid (q_valid),
    .op       (q_op),
    .op_pop   (q_pop),
    .out_valid, .out_stall, .out_module_index, .out_module_rows,
    .out_lap_count, .out_last
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_module_index == 2'd3)
    else $error("last flag off the final module");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_module_index))
    else $error("image changed while stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid || (out_last && !out_stall))
    else $error("frame updated mid-image");

endmodule

FILE: hw/rtl/lmts_ram.sv
// ----------------------------------------------------------------------------
// lmts_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lmts_front.sv
// ----------------------------------------------------------------------------
// lmts_front: command decode and scroll position sequencer
// Keeps the text store and the position counters and turns each tick into
// one column to shift in. Per tick: store read, then glyph lookup.
// ----------------------------------------------------------------------------
module lmts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_text_index,
  input  logic [7:0]         in_char_code,
  input  logic               in_direction,
  input  logic               in_restart,
  input  logic [7:0]         text_length,
  input  logic [7:0]         gap_columns,
  output logic               op_valid,
  output lmts_pkg::op_t      op,
  input  logic               op_full
);

  logic       busy_r, busy_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [2:0] gcol_r, gcol_nxt;
  logic [7:0] gap_r, gap_nxt;
  logic       pdir_r, pdir_nxt;
  logic [7:0] laps_r, laps_nxt;
  logic       right_r, glyph_r;
  logic [2:0] fcol_r;
  logic [7:0] rdata;

  logic       acc, is_tick, right, reload, at_end;
  logic [7:0] start, cpos, ridx;
  logic [2:0] cgcol;

  // a tick waits in stage two for the glyph lookup; stall while busy or queue full
  assign in_stall = busy_r || op_full;
  assign acc      = in_valid && !in_stall;
  assign is_tick  = acc && in_kind == lmts_pkg::KIND_TICK;
  assign right    = in_direction;
  assign start    = right ? text_length - 8'd1 : 8'd0;
  assign reload   = (right != pdir_r) || in_restart;
  assign cpos     = reload ? start : pos_r;
  assign cgcol    = reload ? (right ? lmts_pkg::GLYPH_WIDTH : 3'd0) : gcol_r;
  assign at_end   = right ? (cpos == 8'd255) : (cpos == text_length);
  assign ridx     = right ? text_length - cpos - 8'd1 : cpos;

  lmts_ram #(.WIDTH(8), .DEPTH(lmts_pkg::TEXT_DEPTH)) u_text (
    .clk   (clk),
    .we    (acc && in_kind == lmts_pkg::KIND_WRITE),
    .waddr (in_text_index[lmts_pkg::TEXT_AW-1:0]),
    .wdata (in_char_code),
    .raddr (ridx[lmts_pkg::TEXT_AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    busy_nxt = 1'b0;
    pos_nxt  = pos_r;
    gcol_nxt = gcol_r;
    gap_nxt  = gap_r;
    pdir_nxt = pdir_r;
    laps_nxt = laps_r;
    if (is_tick) begin
      busy_nxt = 1'b1;
      pdir_nxt = right;
      pos_nxt  = cpos;
      gcol_nxt = cgcol;
      if (at_end) begin
        if (gap_r == gap_columns) begin
          pos_nxt  = start;
          gap_nxt  = 8'd1;
          laps_nxt = laps_r + 8'd1;
        end else begin
          gap_nxt = gap_r + 8'd1;
        end
      end else if (right) begin
        if (cgcol == 3'd0) begin
          gcol_nxt = lmts_pkg::GLYPH_WIDTH;
          pos_nxt  = cpos - 8'd1;
        end else begin
          gcol_nxt = cgcol - 3'd1;
        end
      end else if (cgcol == lmts_pkg::GLYPH_WIDTH) begin
        gcol_nxt = 3'd0;
        pos_nxt  = cpos + 8'd1;
      end else begin
        gcol_nxt = cgcol + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
      gcol_r <= '0;
      gap_r  <= '0;
      pdir_r <= 1'b0;
      laps_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      gcol_r <= gcol_nxt;
      gap_r  <= gap_nxt;
      pdir_r <= pdir_nxt;
      laps_r <= laps_nxt;
    end
    if (is_tick) begin
      right_r <= right;
      glyph_r <= !at_end && cgcol != lmts_pkg::GLYPH_WIDTH;
      fcol_r  <= right ? 3'd4 - cgcol : cgcol;
    end
  end

  // clear goes straight out; a tick leaves in the next cycle with its column
  always_comb begin
    op_valid  = busy_r || (acc && in_kind == lmts_pkg::KIND_CLEAR);
    op.clear  = !busy_r;
    op.right  = right_r;
    op.column = glyph_r ? lmts_pkg::glyph_bits(rdata, fcol_r) : 8'd0;
    op.laps   = laps_r;
  end

endmodule

FILE: hw/rtl/lmts_queue.sv
// ----------------------------------------------------------------------------
// lmts_queue: two-entry queue between the sequencer and the frame engine
// Full is raised early enough to cover the front's one in-flight tick.
// ----------------------------------------------------------------------------
module lmts_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lmts_pkg::op_t wdata,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output lmts_pkg::op_t rdata
);

  lmts_pkg::op_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r != 2'd0;
  assign pop_valid = cnt_r != 2'd0;
  assign rdata     = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + (push ? 1'b1 : 1'b0);
    rp_nxt  = rp_r + (pop ? 1'b1 : 1'b0);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/lmts_back.sv
// ----------------------------------------------------------------------------
// lmts_back: frame engine and image output
// Applies one shift or clear to the 32-byte frame, then sends four images.
// ----------------------------------------------------------------------------
module lmts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  lmts_pkg::op_t op,
  output logic          op_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_module_index,
  output logic [63:0]   out_module_rows,
  output logic [7:0]    out_lap_count,
  output logic          out_last
);

  logic [lmts_pkg::RING_BITS-1:0] ring_r [8];
  logic [lmts_pkg::RING_BITS-1:0] ring_nxt [8];
  logic       active_r, active_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] laps_r;
  logic       done;

  assign out_valid        = active_r;
  assign out_module_index = idx_r;
  assign out_lap_count    = laps_r;
  assign out_last         = idx_r == 2'(lmts_pkg::MODULES - 1);
  assign done             = active_r && !out_stall && out_last;
  // next op is applied only once the previous four images are gone
  assign op_pop           = op_valid && (!active_r || done);

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      out_module_rows[8*r +: 8] = ring_r[r][8*idx_r +: 8];
      if (op.clear) begin
        ring_nxt[r] = '0;
      end else if (op.right) begin
        ring_nxt[r] = {ring_r[r][lmts_pkg::RING_BITS-2:0], op.column[r]};
      end else begin
        ring_nxt[r] = {op.column[r], ring_r[r][lmts_pkg::RING_BITS-1:1]};
      end
    end
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (active_r && !out_stall) begin
      idx_nxt = idx_r + 2'd1;
      if (out_last) begin
        active_nxt = 1'b0;
      end
    end
    if (op_pop) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      for (int r = 0; r < 8; r++) begin
        ring_r[r] <= '0;
      end
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      if (op_pop) begin
        for (int r = 0; r < 8; r++) begin
          ring_r[r] <= ring_nxt[r];
        end
      end
    end
    if (op_pop) begin
      laps_r <= op.laps;
    end
  end

endmodule
